@@ hdl/fdre_pkg.sv @@
// Package for the fractional divider register encoder.
// Holds the microcode word layout, the program table, step addresses and device constants.
// No dependencies.
`timescale 1ns / 1ps

package fdre_pkg;

   localparam int PC_W        = 4;
   localparam int INT_W       = 12;
   localparam int FRAC_W      = 20;
   localparam int P1_W        = 18;
   localparam int DIVIDEND_W  = FRAC_W + 7;
   localparam int DIV_STEPS   = DIVIDEND_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

   localparam logic [2:0]        TGT_FB_A    = 3'd0;
   localparam logic [2:0]        TGT_FB_B    = 3'd1;
   localparam logic [2:0]        TGT_OUT0    = 3'd2;
   localparam logic [2:0]        TGT_LAST    = 3'd4;

   localparam logic [INT_W-1:0]  FB_INT_MIN    = 12'd15;
   localparam logic [INT_W-1:0]  FB_INT_LIMIT  = 12'd91;
   localparam logic [INT_W-1:0]  OUT_INT_MIN   = 12'd4;
   localparam logic [INT_W-1:0]  OUT_INT_LIMIT = 12'd2049;

   localparam logic [P1_W-1:0]   P1_OFFSET   = 18'd512;
   localparam logic [FRAC_W-1:0] P2_ONE      = 20'd128;
   localparam logic [FRAC_W-1:0] DENOM_ONE   = 20'd1;

   localparam logic [7:0] FB_A_BASE    = 8'd26;
   localparam logic [7:0] FB_B_BASE    = 8'd34;
   localparam logic [7:0] OUT_BASE     = 8'd42;
   localparam logic [7:0] OUT_CTL_BASE = 8'd16;
   localparam logic [7:0] PLL_RST_ADDR = 8'd177;
   localparam logic [7:0] PLL_RST_VAL  = 8'((1 << 7) | (1 << 5));
   localparam logic [7:0] CTL_BASE_VAL = 8'h0F;
   localparam logic [7:0] CTL_SRC_B    = 8'(1 << 5);
   localparam logic [7:0] CTL_INT_MODE = 8'(1 << 6);

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_RANGE,
      ERR_DENOM,
      ERR_SOURCE
   } err_type;

   typedef enum logic [3:0] {
      SEL_P3_HI,
      SEL_P3_LO,
      SEL_P1_TOP,
      SEL_P1_MID,
      SEL_P1_LO,
      SEL_P32_HI,
      SEL_P2_MID,
      SEL_P2_LO,
      SEL_TAIL,
      SEL_ERR
   } sel_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_GOTO,
      JMP_ON_REQ,
      JMP_ON_ERR,
      JMP_WHILE_BUSY
   } jump_type;

   typedef struct packed {
      logic            accept;
      logic            div_load;
      logic            calc;
      logic            emit;
      sel_type         sel;
      jump_type        jump;
      logic [PC_W-1:0] addr;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic tgt_ok;
      logic err;
      logic div_busy;
      logic slot_free;
   } status_type;

   localparam logic [PC_W-1:0] ST_WAIT   = 4'd0;
   localparam logic [PC_W-1:0] ST_CHECK  = 4'd1;
   localparam logic [PC_W-1:0] ST_DLOAD  = 4'd2;
   localparam logic [PC_W-1:0] ST_DSTEP  = 4'd3;
   localparam logic [PC_W-1:0] ST_CALC   = 4'd4;
   localparam logic [PC_W-1:0] ST_BYTE0  = 4'd5;
   localparam logic [PC_W-1:0] ST_BYTE1  = 4'd6;
   localparam logic [PC_W-1:0] ST_BYTE2  = 4'd7;
   localparam logic [PC_W-1:0] ST_BYTE3  = 4'd8;
   localparam logic [PC_W-1:0] ST_BYTE4  = 4'd9;
   localparam logic [PC_W-1:0] ST_BYTE5  = 4'd10;
   localparam logic [PC_W-1:0] ST_BYTE6  = 4'd11;
   localparam logic [PC_W-1:0] ST_BYTE7  = 4'd12;
   localparam logic [PC_W-1:0] ST_TAIL   = 4'd13;
   localparam logic [PC_W-1:0] ST_ERR    = 4'd14;

   function automatic ctrl_type cw(logic acc, logic ld, logic calc, logic emit,
                                   sel_type sel, jump_type jmp, logic [PC_W-1:0] addr);
      ctrl_type w;
      w.accept   = acc;
      w.div_load = ld;
      w.calc     = calc;
      w.emit     = emit;
      w.sel      = sel;
      w.jump     = jmp;
      w.addr     = addr;
      return w;
   endfunction

   function automatic ctrl_type ucode(logic [PC_W-1:0] pc);
      ctrl_type w;
      case (pc)
         ST_WAIT:  w = cw(1'b1, 1'b0, 1'b0, 1'b0, SEL_ERR,    JMP_ON_REQ,     ST_WAIT);
         ST_CHECK: w = cw(1'b0, 1'b0, 1'b0, 1'b0, SEL_ERR,    JMP_ON_ERR,     ST_ERR);
         ST_DLOAD: w = cw(1'b0, 1'b1, 1'b0, 1'b0, SEL_ERR,    JMP_NEXT,       ST_WAIT);
         ST_DSTEP: w = cw(1'b0, 1'b0, 1'b0, 1'b0, SEL_ERR,    JMP_WHILE_BUSY, ST_WAIT);
         ST_CALC:  w = cw(1'b0, 1'b0, 1'b1, 1'b0, SEL_ERR,    JMP_NEXT,       ST_WAIT);
         ST_BYTE0: w = cw(1'b0, 1'b0, 1'b0, 1'b1, SEL_P3_HI,  JMP_NEXT,       ST_WAIT);
         ST_BYTE1: w = cw(1'b0, 1'b0, 1'b0, 1'b1, SEL_P3_LO,  JMP_NEXT,       ST_WAIT);
         ST_BYTE2: w = cw(1'b0, 1'b0, 1'b0, 1'b1, SEL_P1_TOP, JMP_NEXT,       ST_WAIT);
         ST_BYTE3: w = cw(1'b0, 1'b0, 1'b0, 1'b1, SEL_P1_MID, JMP_NEXT,       ST_WAIT);
         ST_BYTE4: w = cw(1'b0, 1'b0, 1'b0, 1'b1, SEL_P1_LO,  JMP_NEXT,       ST_WAIT);
         ST_BYTE5: w = cw(1'b0, 1'b0, 1'b0, 1'b1, SEL_P32_HI, JMP_NEXT,       ST_WAIT);
         ST_BYTE6: w = cw(1'b0, 1'b0, 1'b0, 1'b1, SEL_P2_MID, JMP_NEXT,       ST_WAIT);
         ST_BYTE7: w = cw(1'b0, 1'b0, 1'b0, 1'b1, SEL_P2_LO,  JMP_NEXT,       ST_WAIT);
         ST_TAIL:  w = cw(1'b0, 1'b0, 1'b0, 1'b1, SEL_TAIL,   JMP_GOTO,       ST_WAIT);
         ST_ERR:   w = cw(1'b0, 1'b0, 1'b0, 1'b1, SEL_ERR,    JMP_GOTO,       ST_WAIT);
         default:  w = cw(1'b0, 1'b0, 1'b0, 1'b0, SEL_ERR,    JMP_GOTO,       ST_WAIT);
      endcase
      return w;
   endfunction

endpackage

@@ hdl/fractional_divider_register_encoder.sv @@
// Fractional divider register encoder: top level with the request, parameter and
// result registers. Depends on fdre_pkg, fdre_seq and fdre_div.
//
// Usage:
//   req_ channel: one word per request (target, source_pll, int_part, numerator,
//   denominator), taken when req_valid and req_ready are both high. req_ready is
//   high only while the sequencer sits at its wait step.
//   rsp_ channel: register writes (address, value), one word per handshake;
//   rsp_last marks the final word of a request. An error gives a single word
//   with its code and zero address and value; targets above 4 give no words.
//   Timing: a good request passes from acceptance through the checks and set-up,
//   the divider (one quotient bit per cycle over 27 bits), the eight parameter
//   writes and the final write, and back to the wait step. An error request
//   goes from the check step to its error word and back to the wait step.
//   Stall: a write step holds while the result register is full and rsp_ready
//   is low; the next request may be taken while the last word still waits.
//   Reset: synchronous, clears the sequencer, divider count, result valid and
//   both feedback configured flags.
`timescale 1ns / 1ps

module fractional_divider_register_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_target,
   input  logic        req_source_pll,
   input  logic [11:0] req_int_part,
   input  logic [19:0] req_numerator,
   input  logic [19:0] req_denominator,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_reg_address,
   output logic [7:0]  rsp_reg_value,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last
);

   fdre_pkg::ctrl_type   ctrl;
   fdre_pkg::status_type status;
   fdre_pkg::err_type    err_code;

   logic [2:0]                      tgt_ff;
   logic                            src_ff;
   logic [fdre_pkg::INT_W-1:0]      a_ff;
   logic [fdre_pkg::FRAC_W-1:0]     b_ff;
   logic [fdre_pkg::FRAC_W-1:0]     c_ff;
   logic [fdre_pkg::P1_W-1:0]       p1_ff, p1_in;
   logic [fdre_pkg::FRAC_W-1:0]     p2_ff, p2_in;
   logic                            fb_a_ff, fb_b_ff;
   logic                            rsp_valid_ff;
   logic [7:0]                      rsp_addr_ff, rsp_value_ff;
   logic [1:0]                      rsp_err_ff;
   logic                            rsp_last_ff;

   logic                            accept;
   logic                            feedback;
   logic                            range_bad;
   logic                            src_ready;
   logic                            slot_free;
   logic                            emit_go;
   logic                            div_busy;
   logic [fdre_pkg::DIVIDEND_W-1:0] quotient;
   logic [fdre_pkg::FRAC_W-1:0]     remainder;
   logic [1:0]                      chan;
   logic [7:0]                      base;
   logic [2:0]                      offset;
   logic [7:0]                      word_addr, word_value;
   logic [7:0]                      ctl_value;

   fdre_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   fdre_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (ctrl.div_load),
      .dividend  ({b_ff, 7'd0}),
      .divisor   (c_ff),
      .busy      (div_busy),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign req_ready = ctrl.accept;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit_go   = ctrl.emit && slot_free;

   assign feedback  = tgt_ff[2:1] == 2'b00;
   assign range_bad = feedback
                    ? (a_ff < fdre_pkg::FB_INT_MIN || a_ff >= fdre_pkg::FB_INT_LIMIT)
                    : (a_ff < fdre_pkg::OUT_INT_MIN || a_ff >= fdre_pkg::OUT_INT_LIMIT);
   assign src_ready = src_ff ? fb_b_ff : fb_a_ff;

   always_comb begin
      if (range_bad) begin
         err_code = fdre_pkg::ERR_RANGE;
      end else if (c_ff == '0) begin
         err_code = fdre_pkg::ERR_DENOM;
      end else if (!feedback && !src_ready) begin
         err_code = fdre_pkg::ERR_SOURCE;
      end else begin
         err_code = fdre_pkg::ERR_NONE;
      end
   end

   always_comb begin
      status.req_valid = req_valid;
      status.tgt_ok    = req_target <= fdre_pkg::TGT_LAST;
      status.err       = err_code != fdre_pkg::ERR_NONE;
      status.div_busy  = div_busy;
      status.slot_free = slot_free;
   end

   always_comb begin
      p1_in = fdre_pkg::P1_W'({a_ff, 7'd0}) + quotient[fdre_pkg::P1_W-1:0]
            - fdre_pkg::P1_OFFSET;
      if (!feedback && b_ff != '0 && c_ff == fdre_pkg::DENOM_ONE) begin
         p2_in = fdre_pkg::FRAC_W'({b_ff, 7'd0}) - fdre_pkg::P2_ONE;
      end else begin
         p2_in = remainder;
      end
   end

   assign chan = 2'(tgt_ff - fdre_pkg::TGT_OUT0);

   always_comb begin
      case (tgt_ff)
         fdre_pkg::TGT_FB_A: base = fdre_pkg::FB_A_BASE;
         fdre_pkg::TGT_FB_B: base = fdre_pkg::FB_B_BASE;
         default:            base = fdre_pkg::OUT_BASE + {3'd0, chan, 3'd0};
      endcase
   end

   always_comb begin
      ctl_value = fdre_pkg::CTL_BASE_VAL;
      if (src_ff) begin
         ctl_value = ctl_value | fdre_pkg::CTL_SRC_B;
      end
      if (b_ff == '0) begin
         ctl_value = ctl_value | fdre_pkg::CTL_INT_MODE;
      end
   end

   always_comb begin
      offset     = 3'd0;
      word_value = 8'd0;
      case (ctrl.sel)
         fdre_pkg::SEL_P3_HI: begin
            offset     = 3'd0;
            word_value = c_ff[15:8];
         end
         fdre_pkg::SEL_P3_LO: begin
            offset     = 3'd1;
            word_value = c_ff[7:0];
         end
         fdre_pkg::SEL_P1_TOP: begin
            offset     = 3'd2;
            word_value = {6'd0, p1_ff[17:16]};
         end
         fdre_pkg::SEL_P1_MID: begin
            offset     = 3'd3;
            word_value = p1_ff[15:8];
         end
         fdre_pkg::SEL_P1_LO: begin
            offset     = 3'd4;
            word_value = p1_ff[7:0];
         end
         fdre_pkg::SEL_P32_HI: begin
            offset     = 3'd5;
            word_value = {c_ff[19:16], p2_ff[19:16]};
         end
         fdre_pkg::SEL_P2_MID: begin
            offset     = 3'd6;
            word_value = p2_ff[15:8];
         end
         fdre_pkg::SEL_P2_LO: begin
            offset     = 3'd7;
            word_value = p2_ff[7:0];
         end
         default: begin
            offset     = 3'd0;
            word_value = 8'd0;
         end
      endcase
   end

   always_comb begin
      case (ctrl.sel)
         fdre_pkg::SEL_TAIL:
            word_addr = feedback ? fdre_pkg::PLL_RST_ADDR
                                 : fdre_pkg::OUT_CTL_BASE + {6'd0, chan};
         fdre_pkg::SEL_ERR:
            word_addr = 8'd0;
         default:
            word_addr = base + {5'd0, offset};
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tgt_ff <= req_target;
         src_ff <= req_source_pll;
         a_ff   <= req_int_part;
         b_ff   <= req_numerator;
         c_ff   <= req_denominator;
      end
      if (ctrl.calc) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_a_ff <= 1'b0;
         fb_b_ff <= 1'b0;
      end else if (emit_go && ctrl.sel == fdre_pkg::SEL_TAIL && feedback) begin
         if (tgt_ff == fdre_pkg::TGT_FB_A) begin
            fb_a_ff <= 1'b1;
         end else begin
            fb_b_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_go) begin
         rsp_addr_ff <= word_addr;
         if (ctrl.sel == fdre_pkg::SEL_TAIL) begin
            rsp_value_ff <= feedback ? fdre_pkg::PLL_RST_VAL : ctl_value;
         end else begin
            rsp_value_ff <= word_value;
         end
         rsp_err_ff  <= (ctrl.sel == fdre_pkg::SEL_ERR) ? err_code : fdre_pkg::ERR_NONE;
         rsp_last_ff <= ctrl.sel == fdre_pkg::SEL_TAIL || ctrl.sel == fdre_pkg::SEL_ERR;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reg_address = rsp_addr_ff;
   assign rsp_reg_value   = rsp_value_ff;
   assign rsp_error_code  = rsp_err_ff;
   assign rsp_last        = rsp_last_ff;

   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != 2'd0
         |-> rsp_reg_address == 8'd0 && rsp_reg_value == 8'd0 && rsp_last)
      else $error("error word carries a write");

   a_fb_a_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(fb_a_ff))
      else $error("feedback A configured flag dropped");

   a_fb_b_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(fb_b_ff))
      else $error("feedback B configured flag dropped");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> !req_ready)
      else $error("request taken while divider runs");

   a_good_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_error_code == 2'd0
         |-> rsp_reg_address == fdre_pkg::PLL_RST_ADDR
          || rsp_reg_address == fdre_pkg::OUT_CTL_BASE
          || rsp_reg_address == fdre_pkg::OUT_CTL_BASE + 8'd1
          || rsp_reg_address == fdre_pkg::OUT_CTL_BASE + 8'd2)
      else $error("final write is not a reset or clock-control write");

endmodule

@@ hdl/fdre_seq.sv @@
// Microcode sequencer: step counter, program table lookup and jump logic.
// Depends on fdre_pkg for the control word, status word and program table.
`timescale 1ns / 1ps

module fdre_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  fdre_pkg::status_type status,
   output fdre_pkg::ctrl_type   ctrl
);

   logic [fdre_pkg::PC_W-1:0] pc_ff;
   logic [fdre_pkg::PC_W-1:0] pc_in;
   logic [fdre_pkg::PC_W-1:0] pc_inc;
   logic                      hold;

   assign ctrl   = fdre_pkg::ucode(pc_ff);
   assign pc_inc = fdre_pkg::PC_W'(pc_ff + 1'b1);
   assign hold   = ctrl.emit && !status.slot_free;

   always_comb begin
      case (ctrl.jump)
         fdre_pkg::JMP_NEXT:       pc_in = pc_inc;
         fdre_pkg::JMP_GOTO:       pc_in = ctrl.addr;
         fdre_pkg::JMP_ON_REQ:     pc_in = (status.req_valid && status.tgt_ok) ? pc_inc : pc_ff;
         fdre_pkg::JMP_ON_ERR:     pc_in = status.err ? ctrl.addr : pc_inc;
         fdre_pkg::JMP_WHILE_BUSY: pc_in = status.div_busy ? pc_ff : pc_inc;
         default:                  pc_in = fdre_pkg::ST_WAIT;
      endcase
      if (hold) begin
         pc_in = pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= fdre_pkg::ST_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ hdl/fdre_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on fdre_pkg for operand widths and the step count.
`timescale 1ns / 1ps

module fdre_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [fdre_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [fdre_pkg::FRAC_W-1:0]       divisor,
   output logic                              busy,
   output logic [fdre_pkg::DIVIDEND_W-1:0]   quotient,
   output logic [fdre_pkg::FRAC_W-1:0]       remainder
);

   logic [fdre_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [fdre_pkg::FRAC_W-1:0]     rem_ff, rem_in;
   logic [fdre_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [fdre_pkg::FRAC_W-1:0]     dvs_ff, dvs_in;
   logic [fdre_pkg::FRAC_W:0]       rem_shift;
   logic                            ge;

   assign busy      = cnt_ff != '0;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign rem_shift = {rem_ff, quo_ff[fdre_pkg::DIVIDEND_W-1]};
   assign ge        = rem_shift >= {1'b0, dvs_ff};

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = fdre_pkg::DIV_CNT_W'(fdre_pkg::DIV_STEPS);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (busy) begin
         cnt_in = fdre_pkg::DIV_CNT_W'(cnt_ff - 1'b1);
         rem_in = ge ? fdre_pkg::FRAC_W'(rem_shift - {1'b0, dvs_ff})
                     : rem_shift[fdre_pkg::FRAC_W-1:0];
         quo_in = {quo_ff[fdre_pkg::DIVIDEND_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

@@ test/tb_top.sv @@
// Self-checking bench for the fractional divider register encoder: a directed table, then
// random requests, all checked word by word against a behavioural predictor of the writes.
// Depends on fdre_pkg and fractional_divider_register_encoder.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [2:0] TGT_OUT1   = fdre_pkg::TGT_OUT0 + 3'd1;
   localparam logic [2:0] TGT_OUT2   = fdre_pkg::TGT_OUT0 + 3'd2;
   localparam logic [2:0] TGT_SPARE0 = fdre_pkg::TGT_LAST + 3'd1;
   localparam logic [2:0] TGT_SPARE1 = fdre_pkg::TGT_LAST + 3'd2;
   localparam logic [2:0] TGT_SPARE2 = fdre_pkg::TGT_LAST + 3'd3;

   localparam int    DIR_N       = 25;
   localparam int    RAND_ITEMS  = 130;
   localparam int    HOLD_CYCLES = 300;
   localparam int    TAIL_CYCLES = 60;
   localparam int    HOLD_AT     = 70;
   localparam int    DRAIN_AT    = 120;
   localparam int    LIMIT_NS    = 2000000;
   localparam [19:0] FRAC_MAX    = 20'hFFFFF;

   typedef struct packed {
      logic [2:0]  target;
      logic        source_pll;
      logic [11:0] int_part;
      logic [19:0] numerator;
      logic [19:0] denominator;
   } req_word_type;

   typedef struct packed {
      logic              typed;
      fdre_pkg::err_type code;
      req_word_type      rq;
   } plan_row_type;

   typedef struct packed {
      logic [7:0]        addr;
      logic [7:0]        val;
      fdre_pkg::err_type err;
      logic              last;
   } reg_write_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_target;
   logic        req_source_pll;
   logic [11:0] req_int_part;
   logic [19:0] req_numerator;
   logic [19:0] req_denominator;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_reg_address;
   logic [7:0]  rsp_reg_value;
   logic [1:0]  rsp_error_code;
   logic        rsp_last;

   reg_write_type pending_writes[$];
   logic          fb_a_set;
   logic          fb_b_set;
   int            bad_words = 0;
   bit            hold_request = 1'b0;

   plan_row_type dir_plan [DIR_N] = '{
      '{1'b1, fdre_pkg::ERR_SOURCE, '{fdre_pkg::TGT_OUT0, 1'b0, 12'd4,    20'd1,    20'd1}},
      '{1'b1, fdre_pkg::ERR_SOURCE, '{TGT_OUT2,           1'b1, 12'd2048, 20'd0,    FRAC_MAX}},
      '{1'b1, fdre_pkg::ERR_RANGE,  '{fdre_pkg::TGT_FB_A, 1'b0, 12'd14,   20'd1,    20'd1}},
      '{1'b1, fdre_pkg::ERR_RANGE,  '{fdre_pkg::TGT_FB_B, 1'b0, 12'd91,   20'd1,    20'd1}},
      '{1'b1, fdre_pkg::ERR_RANGE,  '{TGT_OUT1,           1'b0, 12'd3,    20'd1,    20'd1}},
      '{1'b1, fdre_pkg::ERR_RANGE,  '{fdre_pkg::TGT_OUT0, 1'b0, 12'd2049, 20'd1,    20'd1}},
      '{1'b1, fdre_pkg::ERR_RANGE,  '{fdre_pkg::TGT_FB_A, 1'b0, 12'd0,    20'd0,    20'd0}},
      '{1'b1, fdre_pkg::ERR_RANGE,  '{TGT_OUT2,           1'b1, 12'd4095, FRAC_MAX, FRAC_MAX}},
      '{1'b1, fdre_pkg::ERR_DENOM,  '{fdre_pkg::TGT_FB_A, 1'b0, 12'd15,   20'd1,    20'd0}},
      '{1'b1, fdre_pkg::ERR_DENOM,  '{fdre_pkg::TGT_OUT0, 1'b0, 12'd4,    20'd1,    20'd0}},
      '{1'b0, fdre_pkg::ERR_NONE,   '{TGT_SPARE0,         1'b0, 12'd40,   20'd1,    20'd1}},
      '{1'b0, fdre_pkg::ERR_NONE,   '{TGT_SPARE1,         1'b1, 12'd4095, FRAC_MAX, FRAC_MAX}},
      '{1'b0, fdre_pkg::ERR_NONE,   '{TGT_SPARE2,         1'b0, 12'd0,    20'd0,    20'd0}},
      '{1'b0, fdre_pkg::ERR_NONE,   '{fdre_pkg::TGT_FB_A, 1'b0, 12'd15,   20'd0,    20'd1}},
      '{1'b1, fdre_pkg::ERR_SOURCE, '{TGT_OUT1,           1'b1, 12'd10,   20'd5,    20'd9}},
      '{1'b0, fdre_pkg::ERR_NONE,   '{fdre_pkg::TGT_OUT0, 1'b0, 12'd4,    20'd0,    FRAC_MAX}},
      '{1'b0, fdre_pkg::ERR_NONE,   '{fdre_pkg::TGT_FB_B, 1'b0, 12'd90,   FRAC_MAX, FRAC_MAX}},
      '{1'b0, fdre_pkg::ERR_NONE,   '{fdre_pkg::TGT_FB_A, 1'b0, 12'd50,   FRAC_MAX, 20'd1}},
      '{1'b0, fdre_pkg::ERR_NONE,   '{TGT_OUT1,           1'b1, 12'd2048, FRAC_MAX, 20'd1}},
      '{1'b0, fdre_pkg::ERR_NONE,   '{TGT_OUT2,           1'b0, 12'd100,  20'd3,    20'd7}},
      '{1'b0, fdre_pkg::ERR_NONE,   '{fdre_pkg::TGT_OUT0, 1'b1, 12'd2048, 20'd1,    FRAC_MAX}},
      '{1'b0, fdre_pkg::ERR_NONE,   '{fdre_pkg::TGT_FB_B, 1'b0, 12'd90,   FRAC_MAX, 20'd2}},
      '{1'b0, fdre_pkg::ERR_NONE,   '{TGT_OUT2,           1'b1, 12'd4,    20'd1,    20'd1}},
      '{1'b1, fdre_pkg::ERR_DENOM,  '{TGT_OUT1,           1'b1, 12'd4,    20'd7,    20'd0}},
      '{1'b1, fdre_pkg::ERR_RANGE,  '{fdre_pkg::TGT_FB_B, 1'b1, 12'd4095, 20'd1,    20'd1}}
   };

   fractional_divider_register_encoder u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_target      (req_target),
      .req_source_pll  (req_source_pll),
      .req_int_part    (req_int_part),
      .req_numerator   (req_numerator),
      .req_denominator (req_denominator),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_reg_address (rsp_reg_address),
      .rsp_reg_value   (rsp_reg_value),
      .rsp_error_code  (rsp_error_code),
      .rsp_last        (rsp_last)
   );

   always #2 clock = ~clock;

   function automatic void push_write(input logic [7:0] addr, input logic [7:0] val,
                                      input fdre_pkg::err_type err, input logic last);
      reg_write_type w;
      w.addr = addr;
      w.val  = val;
      w.err  = err;
      w.last = last;
      pending_writes.push_back(w);
   endfunction

   function automatic void encode_request(input req_word_type rq);
      logic [31:0] a, b, c, q, p1, p2, p3;
      logic [7:0]  bytes [8];
      logic [7:0]  base, ctl;
      logic [2:0]  ch;
      logic        feedback, bad_int;
      feedback = (rq.target == fdre_pkg::TGT_FB_A) || (rq.target == fdre_pkg::TGT_FB_B);
      if (rq.target > fdre_pkg::TGT_LAST) return;
      bad_int = feedback
              ? (rq.int_part < fdre_pkg::FB_INT_MIN || rq.int_part >= fdre_pkg::FB_INT_LIMIT)
              : (rq.int_part < fdre_pkg::OUT_INT_MIN || rq.int_part >= fdre_pkg::OUT_INT_LIMIT);
      if (bad_int) begin
         push_write(8'd0, 8'd0, fdre_pkg::ERR_RANGE, 1'b1);
         return;
      end
      if (rq.denominator == 20'd0) begin
         push_write(8'd0, 8'd0, fdre_pkg::ERR_DENOM, 1'b1);
         return;
      end
      if (!feedback && !(rq.source_pll ? fb_b_set : fb_a_set)) begin
         push_write(8'd0, 8'd0, fdre_pkg::ERR_SOURCE, 1'b1);
         return;
      end
      a = 32'(rq.int_part);
      b = 32'(rq.numerator);
      c = 32'(rq.denominator);
      if (b == 32'd0) begin
         p1 = (a << 7) - 32'(fdre_pkg::P1_OFFSET);
         p2 = 32'd0;
         p3 = c;
      end else if (!feedback && c == 32'd1) begin
         p1 = (a << 7) + (b << 7) - 32'(fdre_pkg::P1_OFFSET);
         p2 = (b << 7) - 32'd128;
         p3 = 32'd1;
      end else begin
         q  = (b << 7) / c;
         p1 = (a << 7) + q - 32'(fdre_pkg::P1_OFFSET);
         p2 = (b << 7) - c * q;
         p3 = c;
      end
      bytes[0] = p3[15:8];
      bytes[1] = p3[7:0];
      bytes[2] = {6'd0, p1[17:16]};
      bytes[3] = p1[15:8];
      bytes[4] = p1[7:0];
      bytes[5] = {p3[19:16], p2[19:16]};
      bytes[6] = p2[15:8];
      bytes[7] = p2[7:0];
      ch = rq.target - fdre_pkg::TGT_OUT0;
      if (feedback) begin
         base = (rq.target == fdre_pkg::TGT_FB_A) ? fdre_pkg::FB_A_BASE : fdre_pkg::FB_B_BASE;
      end else begin
         base = fdre_pkg::OUT_BASE + {ch, 3'd0};
      end
      for (int k = 0; k < 8; k++)
         push_write(base + 8'(k), bytes[k], fdre_pkg::ERR_NONE, 1'b0);
      if (feedback) begin
         push_write(fdre_pkg::PLL_RST_ADDR, fdre_pkg::PLL_RST_VAL, fdre_pkg::ERR_NONE, 1'b1);
         if (rq.target == fdre_pkg::TGT_FB_A) fb_a_set = 1'b1;
         else fb_b_set = 1'b1;
      end else begin
         ctl = fdre_pkg::CTL_BASE_VAL;
         if (rq.source_pll) ctl = ctl | fdre_pkg::CTL_SRC_B;
         if (b == 32'd0) ctl = ctl | fdre_pkg::CTL_INT_MODE;
         push_write(fdre_pkg::OUT_CTL_BASE + 8'(ch), ctl, fdre_pkg::ERR_NONE, 1'b1);
      end
   endfunction

   function automatic logic [19:0] rand_frac();
      int w;
      w = $urandom_range(1, 20);
      return 20'($urandom) & 20'((32'd1 << w) - 32'd1);
   endfunction

   // called at a falling edge; returns at a falling edge
   task automatic offer_word(input req_word_type rq, input logic typed,
                             input fdre_pkg::err_type code, input bit eager);
      int gap;
      int roll;
      req_valid       <= 1'b1;
      req_target      <= rq.target;
      req_source_pll  <= rq.source_pll;
      req_int_part    <= rq.int_part;
      req_numerator   <= rq.numerator;
      req_denominator <= rq.denominator;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      if (typed) push_write(8'd0, 8'd0, code, 1'b1);
      else encode_request(rq);
      @(negedge clock);
      roll = $urandom_range(0, 99);
      if (eager || roll < 50) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain_writes();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(negedge clock);
   endtask

   // stimulus
   initial begin
      req_word_type rq;
      int           n;
      int           pick;
      bit           held;
      bit           drained;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_target      = fdre_pkg::TGT_FB_A;
      req_source_pll  = 1'b0;
      req_int_part    = '0;
      req_numerator   = '0;
      req_denominator = '0;
      fb_a_set        = 1'b0;
      fb_b_set        = 1'b0;
      held            = 1'b0;
      drained         = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIR_N; i++)
         offer_word(dir_plan[i].rq, dir_plan[i].typed, dir_plan[i].code, 1'b0);
      drain_writes();

      n = 0;
      while (n < RAND_ITEMS) begin
         pick = $urandom_range(0, 99);
         rq.source_pll  = 1'($urandom_range(0, 1));
         rq.numerator   = rand_frac();
         rq.denominator = rand_frac();
         if (pick < 25) begin
            rq.target   = 3'($urandom_range(fdre_pkg::TGT_FB_A, fdre_pkg::TGT_FB_B));
            rq.int_part = 12'($urandom_range(fdre_pkg::FB_INT_MIN,
                                             fdre_pkg::FB_INT_LIMIT - 1));
         end else if (pick < 85) begin
            rq.target   = 3'($urandom_range(fdre_pkg::TGT_OUT0, fdre_pkg::TGT_LAST));
            rq.int_part = 12'($urandom_range(fdre_pkg::OUT_INT_MIN,
                                             fdre_pkg::OUT_INT_LIMIT - 1));
         end else begin
            rq.target   = 3'($urandom_range(0, 7));
            rq.int_part = 12'($urandom_range(0, 4095));
         end
         if (pick < 85) begin
            if (rq.denominator == 20'd0 || $urandom_range(0, 9) == 0) rq.denominator = 20'd1;
            if ($urandom_range(0, 9) == 0) rq.numerator = 20'd0;
         end
         if (!held && n >= HOLD_AT) begin
            hold_request = 1'b1;
            held = 1'b1;
         end
         offer_word(rq, 1'b0, fdre_pkg::ERR_NONE,
                    (n >= HOLD_AT && n < HOLD_AT + 20) || (n % 50) < 8);
         if (rq.target <= fdre_pkg::TGT_LAST) n++;
         if (!drained && n >= DRAIN_AT) begin
            drain_writes();
            drained = 1'b1;
         end
      end

      drain_writes();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (bad_words == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // result receiver
   initial begin
      bit accepting;
      int run_left;
      accepting = 1'b0;
      run_left  = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            if (run_left == 0) begin
               accepting = !accepting;
               if (accepting) begin
                  run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                         : $urandom_range(1, 16);
               end else begin
                  run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
               end
            end
            rsp_ready <= accepting;
            run_left--;
         end
      end
   end

   // compare each word against the oldest pending write
   always @(posedge clock) begin
      reg_write_type exp_w;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_writes.size() == 0) begin
            if (bad_words < 10)
               $display("%0t: unexpected word addr %0d val %02h err %0d last %0b", $realtime,
                        rsp_reg_address, rsp_reg_value, rsp_error_code, rsp_last);
            bad_words++;
         end else begin
            exp_w = pending_writes.pop_front();
            if (rsp_reg_address !== exp_w.addr || rsp_reg_value !== exp_w.val ||
                rsp_error_code !== exp_w.err || rsp_last !== exp_w.last) begin
               if (bad_words < 10)
                  $display("%0t: word mismatch exp addr %0d val %02h err %0d last %0b, %s",
                           $realtime, exp_w.addr, exp_w.val, exp_w.err, exp_w.last,
                           $sformatf("got addr %0d val %02h err %0d last %0b",
                                     rsp_reg_address, rsp_reg_value, rsp_error_code,
                                     rsp_last));
               bad_words++;
            end
         end
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ files.f @@
hdl/fdre_pkg.sv
hdl/fdre_seq.sv
hdl/fdre_div.sv
hdl/fractional_divider_register_encoder.sv
test/tb_top.sv
